// File: src/pse_pkg.sv
// Shared types, codes and sizes for the postfix stack evaluator.
package pse_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int STEP_W      = $clog2(DATA_W);

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BADOP    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DIVZERO  = 3'd4;

  typedef enum logic [1:0] {
    TK_PUSH,
    TK_FINISH,
    TK_ARITH,
    TK_BAD
  } tok_class_t;

  typedef struct packed {
    tok_class_t        cls;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] operand;
  } token_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/pse_front.sv
// Token classifier and two-entry queue toward the stack engine.
module pse_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pse_pkg::OP_W-1:0]      in_op,
  input  logic [pse_pkg::DATA_W-1:0]    in_operand,
  output logic                          q_valid,
  output pse_pkg::token_t               q_tok,
  input  logic                          q_pop
);

  pse_pkg::token_t q_r [2];
  pse_pkg::token_t tok;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic            push;
  logic            pop;

  always_comb begin
    tok.op      = in_op;
    tok.operand = in_operand;
    unique case (in_op) inside
      pse_pkg::OP_PUSH:   tok.cls = pse_pkg::TK_PUSH;
      pse_pkg::OP_FINISH: tok.cls = pse_pkg::TK_FINISH;
      pse_pkg::OP_ADD, pse_pkg::OP_SUB,
      pse_pkg::OP_MUL, pse_pkg::OP_DIV: tok.cls = pse_pkg::TK_ARITH;
      default:            tok.cls = pse_pkg::TK_BAD;
    endcase
  end

  assign in_stall = (fill_r == 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_tok    = q_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= tok;
    end
  end

endmodule

// File: src/pse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pse_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pse_pkg::div_req_t req,
  output pse_pkg::div_rsp_t rsp
);

  localparam int W = pse_pkg::DATA_W;

  logic                      busy_r;
  logic                      done_r;
  logic                      neg_r;
  logic [W-1:0]              quo_r;
  logic [W-1:0]              rem_r;
  logic [W-1:0]              divs_r;
  logic [W-1:0]              quot_r;
  logic [pse_pkg::STEP_W-1:0] step_r;
  logic [W:0]                shifted;
  logic [W:0]                diff;
  logic                      take;
  logic [W-1:0]              rem_step;
  logic [W-1:0]              quo_step;
  logic                      last;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, divs_r};
    take     = !diff[W];
    rem_step = take ? diff[W-1:0] : shifted[W-1:0];
    quo_step = {quo_r[W-2:0], take};
    last     = busy_r && (step_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r  <= req.dividend[W-1] ^ req.divisor[W-1];
      quo_r  <= req.dividend[W-1] ? -req.dividend : req.dividend;
      divs_r <= req.divisor[W-1] ? -req.divisor : req.divisor;
      rem_r  <= '0;
      step_r <= pse_pkg::STEP_W'(W - 1);
    end else if (busy_r) begin
      quo_r  <= quo_step;
      rem_r  <= rem_step;
      step_r <= step_r - 1'b1;
      // fix the sign as the last bit lands
      if (last) begin
        quot_r <= neg_r ? -quo_step : quo_step;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quot_r;

endmodule

// File: src/pse_back.sv
// Stack engine: operand memory, top register, operator sequencing and result register.
module pse_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  pse_pkg::token_t                q_tok,
  output logic                           q_pop,
  output pse_pkg::div_req_t              div_req,
  input  pse_pkg::div_rsp_t              div_rsp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pse_pkg::DATA_W-1:0]     out_top,
  output logic [pse_pkg::STATUS_W-1:0]   out_stat,
  output logic [pse_pkg::COUNT_W-1:0]    out_count
);

  localparam int W  = pse_pkg::DATA_W;
  localparam int CW = pse_pkg::CNT_W;
  localparam int IW = pse_pkg::IDX_W;

  // the top entry lives in top_r; the memory holds the entries below it
  logic [W-1:0] mem [pse_pkg::STACK_DEPTH];
  logic [W-1:0] rd_data_r;

  pse_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [W-1:0]                 top_r, top_nxt;
  logic [pse_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [W-1:0]                 res_top_r, res_top_nxt;
  logic [pse_pkg::STATUS_W-1:0] res_stat_r, res_stat_nxt;
  logic [CW-1:0]                res_cnt_r, res_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [W-1:0]                 out_top_r;
  logic [pse_pkg::STATUS_W-1:0] out_stat_r;
  logic [pse_pkg::COUNT_W-1:0]  out_count_r;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] cnt_p1;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [W-1:0]  top_or_zero;
  logic [W-1:0]  sum;
  logic [W-1:0]  dif;
  logic [W-1:0]  prod;
  logic          out_load;

  assign cnt_m1      = cnt_r - CW'(1);
  assign cnt_m2      = cnt_r - CW'(2);
  assign cnt_p1      = cnt_r + CW'(1);
  assign rd_addr     = cnt_m2[IW-1:0];
  assign mem_wa      = cnt_m1[IW-1:0];
  assign top_or_zero = (cnt_r != '0) ? top_r : '0;
  assign sum         = rd_data_r + top_r;
  assign dif         = rd_data_r - top_r;
  assign prod        = rd_data_r * top_r;
  assign out_load    = (state_r == pse_pkg::S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    top_nxt      = top_r;
    op_nxt       = op_r;
    res_top_nxt  = res_top_r;
    res_stat_nxt = res_stat_r;
    res_cnt_nxt  = res_cnt_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data_r;
    div_req.divisor  = top_r;

    unique case (state_r)
      pse_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_tok.op;
          state_nxt = pse_pkg::S_OUT;
          res_cnt_nxt = cnt_r;
          unique case (q_tok.cls)
            pse_pkg::TK_PUSH: begin
              if (cnt_r == CW'(pse_pkg::STACK_DEPTH)) begin
                res_top_nxt  = top_r;
                res_stat_nxt = pse_pkg::STAT_OVERFLOW;
              end else begin
                // spill the old top below the new one
                mem_we       = (cnt_r != '0);
                top_nxt      = q_tok.operand;
                cnt_nxt      = cnt_p1;
                res_top_nxt  = q_tok.operand;
                res_stat_nxt = pse_pkg::STAT_OK;
                res_cnt_nxt  = cnt_p1;
              end
            end
            pse_pkg::TK_FINISH: begin
              res_cnt_nxt = '0;
              if (cnt_r == '0) begin
                res_top_nxt  = '0;
                res_stat_nxt = pse_pkg::STAT_UNDERFLOW;
              end else begin
                res_top_nxt  = top_r;
                res_stat_nxt = pse_pkg::STAT_OK;
                cnt_nxt      = '0;
              end
            end
            default: begin
              res_top_nxt = top_or_zero;
              if (cnt_r < CW'(2)) begin
                res_stat_nxt = pse_pkg::STAT_UNDERFLOW;
              end else if (q_tok.cls == pse_pkg::TK_BAD) begin
                res_stat_nxt = pse_pkg::STAT_BADOP;
              end else if (q_tok.op == pse_pkg::OP_DIV && top_r == '0) begin
                res_stat_nxt = pse_pkg::STAT_DIVZERO;
              end else begin
                // fetch the lower operand
                state_nxt = pse_pkg::S_EXEC;
              end
            end
          endcase
        end
      end

      pse_pkg::S_EXEC: begin
        state_nxt    = pse_pkg::S_OUT;
        res_stat_nxt = pse_pkg::STAT_OK;
        res_cnt_nxt  = cnt_m1;
        case (op_r)
          pse_pkg::OP_ADD: begin
            top_nxt = sum; cnt_nxt = cnt_m1; res_top_nxt = sum;
          end
          pse_pkg::OP_SUB: begin
            top_nxt = dif; cnt_nxt = cnt_m1; res_top_nxt = dif;
          end
          pse_pkg::OP_MUL: begin
            top_nxt = prod; cnt_nxt = cnt_m1; res_top_nxt = prod;
          end
          pse_pkg::OP_DIV: begin
            div_req.start = 1'b1;
            state_nxt     = pse_pkg::S_DIV;
          end
          default: begin
            res_top_nxt  = top_r;
            res_stat_nxt = pse_pkg::STAT_BADOP;
            res_cnt_nxt  = cnt_r;
          end
        endcase
      end

      pse_pkg::S_DIV: begin
        if (div_rsp.done) begin
          top_nxt      = div_rsp.quotient;
          cnt_nxt      = cnt_m1;
          res_top_nxt  = div_rsp.quotient;
          res_stat_nxt = pse_pkg::STAT_OK;
          res_cnt_nxt  = cnt_m1;
          state_nxt    = pse_pkg::S_OUT;
        end
      end

      pse_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = pse_pkg::S_IDLE;
        end
      end

      default: state_nxt = pse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pse_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    op_r       <= op_nxt;
    res_top_r  <= res_top_nxt;
    res_stat_r <= res_stat_nxt;
    res_cnt_r  <= res_cnt_nxt;
    if (out_load) begin
      out_top_r   <= res_top_r;
      out_stat_r  <= res_stat_r;
      out_count_r <= pse_pkg::COUNT_W'(res_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= top_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_top   = out_top_r;
  assign out_stat  = out_stat_r;
  assign out_count = out_count_r;

endmodule

// File: src/postfix_stack_evaluator.sv
// Postfix stack evaluator: front classifier and queue, stack engine and divider.
//
// Tokens enter on the in_ channel (in_op, in_operand) and each one gives
// exactly one beat on the out_ channel: the value now on top (or the finished
// result), a status code and the stack depth after the token.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A two-entry queue decouples the token front from the stack engine, so the
// sender is stalled only when that queue is full.
// Push, finish and every error go from the queue straight to the result register;
// add, subtract and multiply first pass an execute state (for the registered
// read of the lower operand from the stack memory), and divide also waits for
// the one-bit-per-cycle divider.
// The engine takes the next token from the queue only once the last result has
// moved into the output register.
// While out_stall is high the finished beat holds in the output register; the
// engine prepares the next result and then waits, and the queue keeps taking
// tokens until it fills.
// Synchronous reset (rst_n low) empties the stack, the queue and the output;
// no clearing pass is needed.
module postfix_stack_evaluator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pse_pkg::OP_W-1:0]             in_op,
  input  logic signed [pse_pkg::DATA_W-1:0]    in_operand,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pse_pkg::DATA_W-1:0]    out_top_value,
  output logic [pse_pkg::STATUS_W-1:0]         out_status,
  output logic [pse_pkg::COUNT_W-1:0]          out_stack_count
);

  logic                          q_valid;
  pse_pkg::token_t               q_tok;
  logic                          q_pop;
  pse_pkg::div_req_t             div_req;
  pse_pkg::div_rsp_t             div_rsp;
  logic [pse_pkg::DATA_W-1:0]    out_top;

  pse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_operand (in_operand),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .q_pop      (q_pop)
  );

  pse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_top   (out_top),
    .out_stat  (out_status),
    .out_count (out_stack_count)
  );

  assign out_top_value = out_top;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the postfix stack evaluator.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_TOKENS  = 1950;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 60;

  // op codes 6 and 7 have no meaning in the block
  localparam logic [pse_pkg::OP_W-1:0] OP_UNK_LO = 3'd6;
  localparam logic [pse_pkg::OP_W-1:0] OP_UNK_HI = 3'd7;

  localparam logic signed [pse_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [pse_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [pse_pkg::DATA_W-1:0] top_value;
    logic [pse_pkg::STATUS_W-1:0]      status;
    logic [pse_pkg::COUNT_W-1:0]       stack_count;
  } result_t;

  typedef struct packed {
    logic [pse_pkg::OP_W-1:0]          op;
    logic signed [pse_pkg::DATA_W-1:0] operand;
    logic                              fixed;
    result_t                           res;
  } token_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [pse_pkg::OP_W-1:0]          in_op;
  logic signed [pse_pkg::DATA_W-1:0] in_operand;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [pse_pkg::DATA_W-1:0] out_top_value;
  logic [pse_pkg::STATUS_W-1:0]      out_status;
  logic [pse_pkg::COUNT_W-1:0]       out_stack_count;

  postfix_stack_evaluator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_operand      (in_operand),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_value   (out_top_value),
    .out_status      (out_status),
    .out_stack_count (out_stack_count)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Operand stack mirror
  logic [pse_pkg::DATA_W-1:0] stack_mirror [pse_pkg::STACK_DEPTH];
  int                         stack_depth;

  result_t    pending_results [$];
  token_row_t directed_rows [$];
  result_t    head_result;
  int         mismatch_count = 0;
  int         tokens_sent;
  int         burst_left;
  int         cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int         stall_left = 0;

  function automatic result_t eval_token(logic [pse_pkg::OP_W-1:0] op,
                                         logic [pse_pkg::DATA_W-1:0] value);
    result_t                    res;
    logic [pse_pkg::DATA_W-1:0] lhs;
    logic [pse_pkg::DATA_W-1:0] rhs;
    logic [pse_pkg::DATA_W-1:0] acc;
    longint                     quot;
    res.status = pse_pkg::STAT_OK;
    res.top_value = '0;
    if (op == pse_pkg::OP_PUSH) begin
      if (stack_depth >= pse_pkg::STACK_DEPTH) begin
        res.status = pse_pkg::STAT_OVERFLOW;
      end else begin
        stack_mirror[stack_depth] = value;
        stack_depth++;
      end
    end else if (op == pse_pkg::OP_FINISH) begin
      if (stack_depth == 0) begin
        res.status = pse_pkg::STAT_UNDERFLOW;
      end else begin
        res.top_value = stack_mirror[stack_depth-1];
        stack_depth = 0;
      end
    end else if (stack_depth < 2) begin
      res.status = pse_pkg::STAT_UNDERFLOW;
    end else begin
      lhs = stack_mirror[stack_depth-2];
      rhs = stack_mirror[stack_depth-1];
      acc = '0;
      case (op)
        pse_pkg::OP_ADD: acc = lhs + rhs;
        pse_pkg::OP_SUB: acc = lhs - rhs;
        pse_pkg::OP_MUL: acc = lhs * rhs;
        pse_pkg::OP_DIV: begin
          if (rhs == '0) begin
            res.status = pse_pkg::STAT_DIVZERO;
          end else begin
            // widen so that the most negative value over minus one wraps cleanly
            quot = longint'($signed(lhs)) / longint'($signed(rhs));
            acc = quot[pse_pkg::DATA_W-1:0];
          end
        end
        default: res.status = pse_pkg::STAT_BADOP;
      endcase
      if (res.status == pse_pkg::STAT_OK) begin
        stack_depth--;
        stack_mirror[stack_depth-1] = acc;
      end
    end
    if (op != pse_pkg::OP_FINISH && stack_depth > 0) begin
      res.top_value = stack_mirror[stack_depth-1];
    end
    res.stack_count = stack_depth[pse_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [pse_pkg::DATA_W-1:0] pick_value();
    logic signed [pse_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 32'sd1;
      2: v = -32'sd1;
      3: v = VAL_MIN;
      4: v = VAL_MAX;
      5, 6: v = int'($urandom_range(0, 200)) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [pse_pkg::OP_W-1:0] pick_arith();
    logic [pse_pkg::OP_W-1:0] op;
    case ($urandom_range(0, 3))
      0: op = pse_pkg::OP_ADD;
      1: op = pse_pkg::OP_SUB;
      2: op = pse_pkg::OP_MUL;
      default: op = pse_pkg::OP_DIV;
    endcase
    return op;
  endfunction

  task automatic add_row(logic [pse_pkg::OP_W-1:0] op,
                         logic signed [pse_pkg::DATA_W-1:0] operand,
                         logic fixed, logic signed [pse_pkg::DATA_W-1:0] top_value,
                         logic [pse_pkg::STATUS_W-1:0] status,
                         logic [pse_pkg::COUNT_W-1:0] count);
    token_row_t row;
    row.op = op;
    row.operand = operand;
    row.fixed = fixed;
    row.res.top_value = top_value;
    row.res.status = status;
    row.res.stack_count = count;
    directed_rows.push_back(row);
  endtask

  // Present one beat, hold it until taken, then record its expected result.
  task automatic send_token(logic [pse_pkg::OP_W-1:0] op,
                            logic signed [pse_pkg::DATA_W-1:0] operand,
                            logic fixed, result_t fixed_res);
    result_t predicted;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_op      <= op;
    in_operand <= operand;
    do @(posedge clk); while (in_stall);
    predicted = eval_token(op, operand);
    pending_results.push_back(fixed ? fixed_res : predicted);
    tokens_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
                                                $urandom_range(1, 16);
    end
  endtask

  task automatic send_random(logic [pse_pkg::OP_W-1:0] op,
                             logic signed [pse_pkg::DATA_W-1:0] operand);
    send_token(op, operand, 1'b0, '0);
  endtask

  // Well-formed expression with random content, sometimes with a stray operator
  // or extra entries pushed on top of the result before the finish.
  task automatic run_expression();
    int pushes_left;
    pushes_left = $urandom_range(1, 12);
    while (pushes_left > 0 || stack_depth > 1) begin
      if (stack_depth < 2 || (pushes_left > 0 && $urandom_range(0, 2) == 0)) begin
        send_random(pse_pkg::OP_PUSH, pick_value());
        pushes_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        send_random($urandom_range(0, 1) ? OP_UNK_HI : OP_UNK_LO, $urandom);
      end else begin
        send_random(pick_arith(), $urandom);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_random(pse_pkg::OP_PUSH, pick_value());
    end
    send_random(pse_pkg::OP_FINISH, $urandom);
  endtask

  // Push until the stack is full, overrun it, sometimes apply an operator, then finish.
  task automatic run_fill();
    while (stack_depth < pse_pkg::STACK_DEPTH) send_random(pse_pkg::OP_PUSH, $urandom);
    repeat ($urandom_range(1, 3)) send_random(pse_pkg::OP_PUSH, $urandom);
    if ($urandom_range(0, 1)) send_random(pick_arith(), $urandom);
    send_random(pse_pkg::OP_FINISH, $urandom);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 10)) begin
      send_random(pse_pkg::OP_W'($urandom_range(0, 7)), $urandom);
    end
  endtask

  // Result side: stall in randomly chosen modes (none, light, heavy, periodic)
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 37) < 24;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: top_value %0d status %0d stack_count %0d",
               out_top_value, out_status, out_stack_count);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_top_value !== head_result.top_value) begin
          $error("top_value: expected %0d, got %0d", head_result.top_value, out_top_value);
          mismatch_count++;
        end
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, out_status);
          mismatch_count++;
        end
        if (out_stack_count !== head_result.stack_count) begin
          $error("stack_count: expected %0d, got %0d", head_result.stack_count,
                 out_stack_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = pse_pkg::OP_PUSH;
    in_operand     = '0;
    stack_depth    = 0;
    tokens_sent    = 0;
    burst_left     = $urandom_range(1, 16);

    // op, operand, fixed, top_value, status, stack_count
    add_row(pse_pkg::OP_FINISH, 32'sd5,  1'b1, '0,      pse_pkg::STAT_UNDERFLOW, 8'd0);
    add_row(pse_pkg::OP_ADD,    -32'sd1, 1'b1, '0,      pse_pkg::STAT_UNDERFLOW, 8'd0);
    add_row(OP_UNK_HI,          '0,      1'b1, '0,      pse_pkg::STAT_UNDERFLOW, 8'd0);
    add_row(pse_pkg::OP_PUSH,   VAL_MAX, 1'b1, VAL_MAX, pse_pkg::STAT_OK,        8'd1);
    add_row(pse_pkg::OP_SUB,    VAL_MIN, 1'b1, VAL_MAX, pse_pkg::STAT_UNDERFLOW, 8'd1);
    add_row(pse_pkg::OP_PUSH,   32'sd1,  1'b1, 32'sd1,  pse_pkg::STAT_OK,        8'd2);
    add_row(pse_pkg::OP_ADD,    '0,      1'b1, VAL_MIN, pse_pkg::STAT_OK,        8'd1);
    add_row(pse_pkg::OP_PUSH,   -32'sd1, 1'b1, -32'sd1, pse_pkg::STAT_OK,        8'd2);
    add_row(pse_pkg::OP_DIV,    VAL_MAX, 1'b1, VAL_MIN, pse_pkg::STAT_OK,        8'd1);
    add_row(pse_pkg::OP_PUSH,   '0,      1'b1, '0,      pse_pkg::STAT_OK,        8'd2);
    add_row(pse_pkg::OP_DIV,    -32'sd1, 1'b1, '0,      pse_pkg::STAT_DIVZERO,   8'd2);
    add_row(OP_UNK_LO,          VAL_MIN, 1'b1, '0,      pse_pkg::STAT_BADOP,     8'd2);
    add_row(OP_UNK_HI,          VAL_MAX, 1'b1, '0,      pse_pkg::STAT_BADOP,     8'd2);
    add_row(pse_pkg::OP_MUL,    -32'sd1, 1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_PUSH,   -32'sd7, 1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_PUSH,   32'sd2,  1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_DIV,    '0,      1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_PUSH,   VAL_MIN, 1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_MUL,    '0,      1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_SUB,    '0,      1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_PUSH,   VAL_MAX, 1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_FINISH, '0,      1'b0, '0, pse_pkg::STAT_OK, '0);
    add_row(pse_pkg::OP_PUSH,   VAL_MIN, 1'b1, VAL_MIN, pse_pkg::STAT_OK,        8'd1);
    add_row(pse_pkg::OP_FINISH, -32'sd1, 1'b1, VAL_MIN, pse_pkg::STAT_OK,        8'd0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_token(directed_rows[i].op, directed_rows[i].operand,
                 directed_rows[i].fixed, directed_rows[i].res);
    end

    run_fill();
    while (tokens_sent < directed_rows.size() + RANDOM_TOKENS) begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   run_fill();
        [2:16]:  run_noise();
        default: run_expression();
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/pse_pkg.sv
src/pse_front.sv
src/pse_div.sv
src/pse_back.sv
src/postfix_stack_evaluator.sv
sim/tb_top.sv
